FILE: src/nearest_palette_color_mapper_top_assert.svh
// Assertion macros used by the bound assertion checker.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_TOP_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define NPCM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npcm assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define NPCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npcm assertion failed");

`endif

FILE: src/npcm_pkg.sv
package npcm_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 64;
   localparam int INDEX_WIDTH     = $clog2(PALETTE_ENTRIES);
   localparam int COLOR_WIDTH     = 8;
   localparam int ENTRY_WIDTH     = 3 * COLOR_WIDTH;
   localparam int SQUARE_WIDTH    = 2 * COLOR_WIDTH;
   // three squares of 8-bit differences fit in 18 bits
   localparam int DIST_WIDTH      = SQUARE_WIDTH + 2;

   // Request operations
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BEGIN = 2'd1,
      OP_MAP   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Control register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNIQUE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_BLACKER  = 2'd1;

   // Entries excluded whenever an image begins
   localparam int NUM_EXCLUDED = 8;
   localparam logic [INDEX_WIDTH-1:0] EXCLUDED_ENTRIES [NUM_EXCLUDED] = '{
      6'h0E, 6'h1E, 6'h2E, 6'h3E, 6'h0F, 6'h1F, 6'h2F, 6'h3F
   };
   localparam logic [INDEX_WIDTH-1:0] BLACKER_BLACK_ENTRY = 6'h0D;

   // Tag that travels with an entry through the distance pipeline
   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] index;
   } tag_type;

   // Availability mask at the start of an image
   function automatic logic [PALETTE_ENTRIES-1:0] begin_mask(input logic block_blacker);
      logic [PALETTE_ENTRIES-1:0] mask;
      mask = '1;
      for (int i = 0; i < NUM_EXCLUDED; i++) begin
         mask[EXCLUDED_ENTRIES[i]] = 1'b0;
      end
      if (block_blacker) begin
         mask[BLACKER_BLACK_ENTRY] = 1'b0;
      end
      return mask;
   endfunction

endpackage

FILE: src/npcm_ram.sv
module npcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/npcm_dist_unit.sv
module npcm_dist_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  npcm_pkg::tag_type                    in_tag,
   input  logic [npcm_pkg::ENTRY_WIDTH-1:0]     in_color,
   input  logic [npcm_pkg::ENTRY_WIDTH-1:0]     in_entry,
   output npcm_pkg::tag_type                    out_tag,
   output logic [npcm_pkg::DIST_WIDTH-1:0]      out_dist,
   output logic                                 busy
);
   import npcm_pkg::*;

   // Absolute difference of two components
   function automatic logic [COLOR_WIDTH-1:0] abs_diff(
      input logic [COLOR_WIDTH-1:0] a,
      input logic [COLOR_WIDTH-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [COLOR_WIDTH-1:0]  diff_r, diff_g, diff_b;
   logic [SQUARE_WIDTH-1:0] sq_r_in, sq_g_in, sq_b_in;
   logic [SQUARE_WIDTH-1:0] sq_r_ff, sq_g_ff, sq_b_ff;
   logic [DIST_WIDTH-1:0]   dist_in, dist_ff;
   tag_type                 tag_a_ff, tag_b_ff;

   // Stage A: per-component squared difference
   always_comb begin
      diff_r  = abs_diff(in_color[3*COLOR_WIDTH-1:2*COLOR_WIDTH],
                         in_entry[3*COLOR_WIDTH-1:2*COLOR_WIDTH]);
      diff_g  = abs_diff(in_color[2*COLOR_WIDTH-1:COLOR_WIDTH],
                         in_entry[2*COLOR_WIDTH-1:COLOR_WIDTH]);
      diff_b  = abs_diff(in_color[COLOR_WIDTH-1:0], in_entry[COLOR_WIDTH-1:0]);
      sq_r_in = SQUARE_WIDTH'(diff_r) * SQUARE_WIDTH'(diff_r);
      sq_g_in = SQUARE_WIDTH'(diff_g) * SQUARE_WIDTH'(diff_g);
      sq_b_in = SQUARE_WIDTH'(diff_b) * SQUARE_WIDTH'(diff_b);
   end

   // Stage B: sum of the three squares
   assign dist_in = DIST_WIDTH'(sq_r_ff) + DIST_WIDTH'(sq_g_ff) + DIST_WIDTH'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
      end else begin
         tag_a_ff.valid <= in_tag.valid;
         tag_b_ff.valid <= tag_a_ff.valid;
      end
      tag_a_ff.index <= in_tag.index;
      tag_b_ff.index <= tag_a_ff.index;
      sq_r_ff        <= sq_r_in;
      sq_g_ff        <= sq_g_in;
      sq_b_ff        <= sq_b_in;
      dist_ff        <= dist_in;
   end

   assign out_tag  = tag_b_ff;
   assign out_dist = dist_ff;
   assign busy     = tag_a_ff.valid || tag_b_ff.valid;

endmodule

FILE: src/nearest_palette_color_mapper_top.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  opcode, entry_index, red, green, blue
// rsp      out        rsp_valid/rsp_ready  color_index
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Map requests read all 64 palette entries through the single RAM read port, one per
// cycle into the distance unit, then wait for the pipeline to drain and hand off the result.
// Write-entry, begin-image and unused opcodes go straight from idle to the done state.
// Reset is synchronous; it sets the availability mask to all ones and the controls to defaults.
// A pending response may sit in the output register while a new request is taken.
// csr writes are always accepted and are meant only while the block is idle.
module nearest_palette_color_mapper_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_opcode,
   input  logic [npcm_pkg::INDEX_WIDTH-1:0]      req_entry_index,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]      req_red,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]      req_green,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]      req_blue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [npcm_pkg::INDEX_WIDTH-1:0]      rsp_color_index,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [npcm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic                                  csr_data
);
   import npcm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   localparam logic [INDEX_WIDTH-1:0] LAST_ENTRY = INDEX_WIDTH'(PALETTE_ENTRIES - 1);

   state_type                   state_ff, state_in;
   logic [INDEX_WIDTH-1:0]      scan_cnt_ff, scan_cnt_in;
   logic [ENTRY_WIDTH-1:0]      color_ff, color_in;
   tag_type                     p0_tag_ff, p0_tag_in;
   logic [INDEX_WIDTH-1:0]      best_idx_ff, best_idx_in;
   logic [DIST_WIDTH-1:0]       best_dist_ff, best_dist_in;
   logic                        best_found_ff, best_found_in;
   logic [INDEX_WIDTH-1:0]      result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0]      rsp_index_ff, rsp_index_in;
   logic [PALETTE_ENTRIES-1:0]  mask_ff, mask_in;
   logic                        unique_ff, unique_in;
   logic                        block_bb_ff, block_bb_in;

   logic                        req_accept;
   logic                        rsp_free;
   logic                        wr_en;
   logic                        rd_en;
   logic [ENTRY_WIDTH-1:0]      req_rgb;
   logic [ENTRY_WIDTH-1:0]      rd_entry;
   tag_type                     dist_tag;
   logic [DIST_WIDTH-1:0]       cand_dist;
   logic                        dist_busy;
   logic                        cand_ok;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;
   assign req_rgb    = {req_red, req_green, req_blue};
   assign wr_en      = req_accept && (opcode_type'(req_opcode) == OP_WRITE);
   assign rd_en      = (state_ff == ST_SCAN);

   // Palette store
   npcm_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index),
      .wr_data (req_rgb),
      .rd_en   (rd_en),
      .rd_addr (scan_cnt_ff),
      .rd_data (rd_entry)
   );

   // Shared distance unit, one entry per cycle
   npcm_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (p0_tag_ff),
      .in_color (color_ff),
      .in_entry (rd_entry),
      .out_tag  (dist_tag),
      .out_dist (cand_dist),
      .busy     (dist_busy)
   );

   // An available candidate beats the running best; strict less keeps the first on a tie
   assign cand_ok = dist_tag.valid && mask_ff[dist_tag.index] &&
                    (!best_found_ff || (cand_dist < best_dist_ff));

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      color_in      = color_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_found_in = best_found_ff;
      result_in     = result_ff;
      mask_in       = mask_ff;
      unique_in     = unique_ff;
      block_bb_in   = block_bb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;

      p0_tag_in.valid = (state_ff == ST_SCAN);
      p0_tag_in.index = scan_cnt_ff;

      // running minimum
      if (cand_ok) begin
         best_found_in = 1'b1;
         best_dist_in  = cand_dist;
         best_idx_in   = dist_tag.index;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               result_in = '0;
               state_in  = ST_DONE;
               case (opcode_type'(req_opcode))
                  OP_BEGIN: begin
                     mask_in = begin_mask(block_bb_ff);
                  end
                  OP_MAP: begin
                     color_in      = req_rgb;
                     scan_cnt_in   = '0;
                     best_found_in = 1'b0;
                     best_idx_in   = '0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LAST_ENTRY) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p0_tag_ff.valid && !dist_busy) begin
               result_in = best_idx_ff;
               if (unique_ff) begin
                  mask_in[best_idx_ff] = 1'b0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // control registers
      if (csr_valid) begin
         case (csr_index)
            CSR_UNIQUE_MODE:   unique_in   = csr_data;
            CSR_BLOCK_BLACKER: block_bb_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         p0_tag_ff.valid <= 1'b0;
         best_found_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mask_ff         <= '1;
         unique_ff       <= 1'b0;
         block_bb_ff     <= 1'b1;
      end else begin
         state_ff        <= state_in;
         p0_tag_ff.valid <= p0_tag_in.valid;
         best_found_ff   <= best_found_in;
         rsp_valid_ff    <= rsp_valid_in;
         mask_ff         <= mask_in;
         unique_ff       <= unique_in;
         block_bb_ff     <= block_bb_in;
      end
      p0_tag_ff.index <= p0_tag_in.index;
      scan_cnt_ff     <= scan_cnt_in;
      color_ff        <= color_in;
      best_idx_ff     <= best_idx_in;
      best_dist_ff    <= best_dist_in;
      result_ff       <= result_in;
      rsp_index_ff    <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_index_ff;

endmodule

FILE: src/npcm_checker.sv
`include "nearest_palette_color_mapper_top_assert.svh"

module npcm_assert_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_opcode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [npcm_pkg::INDEX_WIDTH-1:0]  rsp_color_index
);
   import npcm_pkg::*;

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff, pending_in;
   logic       last_nonmap_ff, last_nonmap_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Requests taken whose response is not yet delivered
   always_comb begin
      pending_in     = pending_ff + 2'(req_acc) - 2'(rsp_acc);
      last_nonmap_in = last_nonmap_ff;
      if (req_acc) begin
         last_nonmap_in = (opcode_type'(req_opcode) != OP_MAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         last_nonmap_ff <= 1'b0;
      end else begin
         pending_ff     <= pending_in;
         last_nonmap_ff <= last_nonmap_in;
      end
   end

   // A stalled response holds
   `NPCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_color_index))
   // No response without a request behind it
   `NPCM_ASSERT_IMPL(a_rsp_has_req, rsp_acc, pending_ff != 2'd0)
   // At most one in work plus one in the output register
   `NPCM_ASSERT_IMPL(a_pending_bound, 1'b1, pending_ff != 2'd3)
   // Non-map requests answer zero
   `NPCM_ASSERT_IMPL(a_nonmap_zero, rsp_acc && pending_ff == 2'd1 && last_nonmap_ff,
                     rsp_color_index == '0)

endmodule

bind nearest_palette_color_mapper_top npcm_assert_checker u_npcm_checker (.*);

FILE: dv/npcm_checker.sv
// Watches the request, response and control channels of the palette mapper,
// predicts each response and compares it with what the block returns.
module npcm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic [npcm_pkg::INDEX_WIDTH-1:0]     req_entry_index,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]     req_red,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]     req_green,
   input  logic [npcm_pkg::COLOR_WIDTH-1:0]     req_blue,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [npcm_pkg::INDEX_WIDTH-1:0]     rsp_color_index,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [npcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic                                 csr_data,
   output int                                   outstanding,
   output int                                   fail_count
);
   import npcm_pkg::*;

   // entries 0x0E/0x0F, 0x1E/0x1F, 0x2E/0x2F, 0x3E/0x3F never start an image free
   localparam logic [PALETTE_ENTRIES-1:0] RESERVED_ENTRIES = 64'hC000_C000_C000_C000;
   // blacker-than-black entry, held back when the guard is on
   localparam int GUARD_ENTRY = 'h0D;
   localparam int MAX_REPORTS = 10;

   logic [ENTRY_WIDTH-1:0]     palette_copy [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] free_entries;
   logic                       unique_sel;
   logic                       guard_sel;
   logic [INDEX_WIDTH-1:0]     pending_index [$];
   int                         mismatches;

   function automatic int unsigned sq_diff(input logic [7:0] a, input logic [7:0] b);
      int unsigned d;
      d = (a > b) ? 32'(a - b) : 32'(b - a);
      return d * d;
   endfunction

   // Closest free entry; lowest index wins a tie, 0 when nothing is free
   function automatic logic [INDEX_WIDTH-1:0] nearest_entry(input logic [7:0] r,
                                                            input logic [7:0] g,
                                                            input logic [7:0] b);
      int unsigned            best;
      int unsigned            span;
      logic [INDEX_WIDTH-1:0] pick;
      bit                     found;
      best  = 0;
      pick  = '0;
      found = 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         if (free_entries[i]) begin
            span = sq_diff(r, palette_copy[i][23:16]) + sq_diff(g, palette_copy[i][15:8])
                 + sq_diff(b, palette_copy[i][7:0]);
            if (!found || span < best) begin
               found = 1'b1;
               best  = span;
               pick  = INDEX_WIDTH'(i);
            end
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin
      logic [INDEX_WIDTH-1:0] hit;
      if (reset) begin
         foreach (palette_copy[i]) palette_copy[i] = '0;
         free_entries = '1;
         unique_sel   = 1'b0;
         guard_sel    = 1'b1;
         pending_index.delete();
         mismatches   = 0;
      end else begin
         // a response always belongs to an older request, so match it first
         if (rsp_valid && rsp_ready) begin
            if (pending_index.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("npcm_checker: response color_index=%0d with no request waiting",
                           rsp_color_index);
            end else begin
               hit = pending_index.pop_front();
               if (rsp_color_index !== hit) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("npcm_checker: color_index expected %0d, got %0d",
                              hit, rsp_color_index);
               end
            end
         end

         // control writes; only bit 0 of the data exists, spare indexes do nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UNIQUE_MODE:   unique_sel = csr_data;
               CSR_BLOCK_BLACKER: guard_sel  = csr_data;
               default: ;
            endcase
         end

         // requests: every opcode yields exactly one response
         if (req_valid && req_ready) begin
            hit = '0;
            case (opcode_type'(req_opcode))
               OP_WRITE: palette_copy[req_entry_index] = {req_red, req_green, req_blue};
               OP_BEGIN: begin
                  free_entries = ~RESERVED_ENTRIES;
                  if (guard_sel) free_entries[GUARD_ENTRY] = 1'b0;
               end
               OP_MAP: begin
                  hit = nearest_entry(req_red, req_green, req_blue);
                  if (unique_sel) free_entries[hit] = 1'b0;
               end
               default: ;
            endcase
            pending_index = {pending_index, hit};
         end
      end
      outstanding <= pending_index.size();
      fail_count  <= mismatches;
   end

endmodule

FILE: dv/tb.sv
// Stimulus and verdict for the palette mapper; checking lives in npcm_checker.
module tb;
   import npcm_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1550;
   localparam int SEGMENTS     = 6;
   localparam int DRAIN_CYCLES = 150;
   // spare control indexes, ignored by the block
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_opcode      = '0;
   logic [INDEX_WIDTH-1:0]     req_entry_index = '0;
   logic [COLOR_WIDTH-1:0]     req_red         = '0;
   logic [COLOR_WIDTH-1:0]     req_green       = '0;
   logic [COLOR_WIDTH-1:0]     req_blue        = '0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [INDEX_WIDTH-1:0]     rsp_color_index;
   logic                       csr_valid       = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index       = '0;
   logic                       csr_data        = 1'b0;

   int send_idle_pct = 35;
   int recv_idle_pct = 50;
   int outstanding;
   int fail_count;
   int n_map, n_write, n_begin, n_ignored;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   nearest_palette_color_mapper_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   npcm_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_color_index (rsp_color_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .outstanding     (outstanding),
      .fail_count      (fail_count)
   );

   // response back-pressure
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // One request; valid stays up across back-to-back requests
   task automatic send_request(input opcode_type op, input logic [INDEX_WIDTH-1:0] idx,
                               input logic [ENTRY_WIDTH-1:0] rgb);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      {req_red, req_green, req_blue} <= rgb;
      do @(posedge clock); while (!req_ready);
      case (op)
         OP_MAP:   n_map++;
         OP_WRITE: n_write++;
         OP_BEGIN: n_begin++;
         default:  n_ignored++;
      endcase
   endtask

   task automatic send_map(input logic [ENTRY_WIDTH-1:0] rgb);
      send_request(OP_MAP, INDEX_WIDTH'($urandom), rgb);
   endtask

   // Drop valid and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Spare index first, then both real registers; block must be idle
   task automatic program_config(input logic unique_on, input logic guard_on);
      logic [CSR_INDEX_WIDTH-1:0] idx_list [3];
      logic                       data_list [3];
      idx_list[0]  = $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
      data_list[0] = 1'($urandom);
      idx_list[1]  = CSR_UNIQUE_MODE;
      data_list[1] = unique_on;
      idx_list[2]  = CSR_BLOCK_BLACKER;
      data_list[2] = guard_on;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data  <= data_list[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Palette colors: half on a coarse grid so exact ties show up
   function automatic logic [ENTRY_WIDTH-1:0] palette_color();
      if ($urandom_range(0, 1))
         return {8'(85 * $urandom_range(0, 3)), 8'(85 * $urandom_range(0, 3)),
                 8'(85 * $urandom_range(0, 3))};
      return ENTRY_WIDTH'($urandom);
   endfunction

   // Begin an image and map distinct colors in ascending order
   task automatic run_image(input bit exhaust);
      logic [ENTRY_WIDTH:0] shade;
      int                   count;
      send_request(OP_BEGIN, INDEX_WIDTH'($urandom), ENTRY_WIDTH'($urandom));
      count = exhaust ? $urandom_range(56, 64) : $urandom_range(1, 40);
      shade = (ENTRY_WIDTH+1)'($urandom_range(0, 'h1F_FFFF));
      for (int i = 0; i < count; i++) begin
         if (shade > 25'hFF_FFFF) break;
         send_map(shade[ENTRY_WIDTH-1:0]);
         shade = shade + (ENTRY_WIDTH+1)'(($urandom_range(0, 3) == 0)
                                          ? $urandom_range(1, 4)
                                          : $urandom_range(1, 240000));
      end
   endtask

   initial begin
      int base;
      int pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // load every entry before any lookup; black at 0 and 0x0D, white at 63
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         if (i == 0 || i == 'h0D)
            send_request(OP_WRITE, INDEX_WIDTH'(i), 24'h000000);
         else if (i == PALETTE_ENTRIES - 1)
            send_request(OP_WRITE, INDEX_WIDTH'(i), 24'hFFFFFF);
         else
            send_request(OP_WRITE, INDEX_WIDTH'(i), palette_color());
      end

      // lookups before any image begins: every entry is a candidate
      send_map(24'h000000);
      send_map(24'hFFFFFF);
      send_request(OP_NONE, 6'h3F, 24'hFFFFFF);
      send_request(OP_WRITE, 6'd5, 24'hFFFFFF);
      send_request(OP_WRITE, 6'h0E, 24'h020202);
      send_request(OP_WRITE, 6'd20, 24'h808080);
      send_request(OP_WRITE, 6'd40, 24'h808080);
      // reserved entry must lose even on an exact match; tie goes to the lower entry
      send_request(OP_BEGIN, 6'h00, 24'h000000);
      send_map(24'hFFFFFF);
      send_map(24'h020202);
      send_map(24'h808080);
      send_map(24'h808080);

      // unique mode: tied entries are used up one after the other
      settle();
      program_config(1'b1, 1'b1);
      send_request(OP_BEGIN, 6'h3F, 24'hFFFFFF);
      send_map(24'h808080);
      send_map(24'h808080);
      send_map(24'h000000);
      send_map(24'h000000);

      // guard off: the blacker-than-black entry becomes usable
      settle();
      program_config(1'b1, 1'b0);
      send_request(OP_BEGIN, 6'h00, 24'h000000);
      send_map(24'h000000);
      send_map(24'h000000);

      // random part: four settings under three idle profiles
      base = n_map + n_write + n_begin;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         case (seg / 2)
            0:       begin send_idle_pct = 35; recv_idle_pct = 50; end
            1:       begin send_idle_pct = 50; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         program_config(seg[0], !seg[1]);
         while (n_map + n_write + n_begin - base < (seg + 1) * RANDOM_ITEMS / SEGMENTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               run_image($urandom_range(0, 3) == 0);
            else if (pick < 80)
               repeat ($urandom_range(1, 8))
                  send_request(OP_WRITE, INDEX_WIDTH'($urandom), palette_color());
            else if (pick < 92)
               send_map(ENTRY_WIDTH'($urandom));
            else if (pick < 96)
               send_request(OP_BEGIN, INDEX_WIDTH'($urandom), ENTRY_WIDTH'($urandom));
            else
               send_request(OP_NONE, INDEX_WIDTH'($urandom), ENTRY_WIDTH'($urandom));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d requests: %0d map, %0d entry write, %0d begin image, %0d unused opcode",
               n_map + n_write + n_begin + n_ignored, n_map, n_write, n_begin, n_ignored);
      $display("tb: all unique/guard settings under three idle profiles, images run dry");
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // hang guard
   initial begin
      #12_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/npcm_pkg.sv
src/npcm_ram.sv
src/npcm_dist_unit.sv
src/nearest_palette_color_mapper_top.sv
src/npcm_checker.sv
dv/npcm_checker.sv
dv/tb.sv
